FILE: rtl/lsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg
// shared types and constants of the latency statistics accumulator
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int BUCKETS     = 16;
    localparam int BUCKET_W    = 4;
    localparam int BATCH_LIMIT = 64;
    localparam int BC_W        = $clog2(BATCH_LIMIT);

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_COLLECT = 1'b1;

    // one bucket record as held in memory
    typedef struct packed {
        logic [63:0]     min_val;
        logic [63:0]     max_val;
        logic [63:0]     mean;
        logic [31:0]     count;
        logic [63:0]     batch_sum;
        logic [BC_W-1:0] batch_count;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_DIV,
        ST_FIN
    } state_t;

    // record of a cleared bucket
    function automatic rec_t clear_rec();
        rec_t r;
        r.min_val     = '1;
        r.max_val     = '0;
        r.mean        = '0;
        r.count       = '0;
        r.batch_sum   = '0;
        r.batch_count = '0;
        return r;
    endfunction

endpackage

FILE: rtl/lsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/latency_stat_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stat_accumulator
// per-bucket min / max / running mean statistics over a stream of samples
// ----------------------------------------------------------------------------
// an add without flush reads the ram, then modifies and writes back the record
// a flush adds the multiply states mul1 and mul2, the numerator state, the
// one-bit-per-cycle restoring divider (skipped when the new count is zero)
// and the write-back state; a collect without a pending batch goes through
// eval and fin, plus any wait on the output register
// reset (rst_n, async) clears all bucket valid bits: every bucket reads as cleared
// ----------------------------------------------------------------------------
module latency_stat_accumulator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // bucket_index[3:0], sample_value[67:4], zero fill
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata    // bucket_out[3:0], min_out[67:4], max_out[131:68],
                                    // mean_out[195:132], count_out[227:196], zero fill
);
    import lsa_pkg::*;

    state_t state_reg, state_next;

    // per-bucket valid bits, an invalid entry reads as a cleared record
    logic [BUCKETS-1:0] valid_reg, valid_next;
    logic               rvalid_reg;

    // latched item
    logic                cmd_reg;
    logic [BUCKET_W-1:0] bkt_reg;
    logic [63:0]         val_reg;

    // working record and flush datapath
    rec_t        work_reg, work_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dm_reg, dm_next;
    logic        qneg_reg, qneg_next;
    logic [5:0]  step_reg, step_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [227:0]        out_data_reg, out_data_next;

    logic        accept;
    logic        ram_we;
    rec_t        ram_wdata, ram_rdata, cur;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

    lsa_ram #(
        .WIDTH (REC_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bkt_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_tdata[3:0]),
        .rdata (ram_rdata)
    );

    assign cur = rvalid_reg ? ram_rdata : clear_rec();

    // flush arithmetic
    logic [63:0] sum_v;
    logic        sum_ovf;
    logic        need_flush;
    logic [31:0] den32;
    logic [63:0] num;
    logic [63:0] den64;
    logic [32:0] rem_try;
    logic [32:0] rem_sub;

    always_comb
    begin
        {sum_ovf, sum_v} = {1'b0, cur.batch_sum} + {1'b0, val_reg};
        need_flush = (cur.batch_count != '0) &&
                     (sum_ovf || ({1'b0, cur.batch_count} + 1'b1 >= (BC_W+1)'(BATCH_LIMIT)));
        den32 = work_reg.count + 32'(work_reg.batch_count);
        den64 = {{32{den32[31]}}, den32};
        // low 64 bits of mean * sext(count) plus the batch sum
        num = p0_reg + {p1_reg, 32'b0}
              - (work_reg.count[31] ? {work_reg.mean[31:0], 32'b0} : 64'd0)
              + work_reg.batch_sum;
        rem_try = {rem_reg[31:0], quo_reg[63]};
        rem_sub = rem_try - {1'b0, dm_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        work_next      = work_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dm_next        = dm_reg;
        qneg_next      = qneg_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_wdata      = work_reg;

        // output transaction taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                work_next = cur;
                if (cmd_reg == CMD_ADD)
                begin
                    if (val_reg < cur.min_val)
                    begin
                        work_next.min_val = val_reg;
                    end
                    if (val_reg > cur.max_val)
                    begin
                        work_next.max_val = val_reg;
                    end
                    if (need_flush)
                    begin
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        // plain add, write back at once
                        work_next.batch_sum   = sum_v;
                        work_next.batch_count = cur.batch_count + 1'b1;
                        ram_we                = 1'b1;
                        ram_wdata             = work_next;
                        valid_next[bkt_reg]   = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
                else if (cur.batch_count != '0)
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL1:
            begin
                p0_next    = {32'b0, work_reg.mean[31:0]} * {32'b0, work_reg.count};
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                p1_next    = work_reg.mean[63:32] * work_reg.count;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                quo_next        = num[63] ? (64'd0 - num) : num;
                dm_next         = den64[63] ? 32'(64'd0 - den64) : den32;
                qneg_next       = num[63] ^ den64[63];
                rem_next        = '0;
                step_next       = '1;
                work_next.count = den32;
                work_next.batch_sum   = '0;
                work_next.batch_count = '0;
                state_next      = (den32 == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (!rem_sub[32])
                begin
                    rem_next = rem_sub;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_try;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    work_next.mean = qneg_reg ? (64'd0 - quo_next) : quo_next;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    work_next.batch_sum   = val_reg;
                    work_next.batch_count = BC_W'(1);
                    ram_we                = 1'b1;
                    ram_wdata             = work_next;
                    valid_next[bkt_reg]   = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (work_reg.count == '0)
                    begin
                        out_data_next = {32'd0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, bkt_reg};
                    end
                    else
                    begin
                        out_data_next = {work_reg.count, work_reg.mean, work_reg.max_val,
                                         work_reg.min_val, bkt_reg};
                    end
                    // clearing a bucket is dropping its valid bit
                    valid_next[bkt_reg] = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            bkt_reg    <= s_tdata[3:0];
            val_reg    <= s_tdata[67:4];
            rvalid_reg <= valid_reg[s_tdata[3:0]];
        end
        work_reg     <= work_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dm_reg       <= dm_next;
        qneg_reg     <= qneg_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/lsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_checker
// port-level checks of the latency statistics accumulator
// ----------------------------------------------------------------------------
module lsa_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [231:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // empty bucket reports cleared values
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[227:196] == 32'd0) |->
        (m_tdata[67:4] == 64'hFFFF_FFFF_FFFF_FFFF) && (m_tdata[131:68] == 64'd0) &&
        (m_tdata[195:132] == 64'd0))
        else $error("empty bucket not reported as cleared");

    // min never above max for a nonempty bucket
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[227:196] != 32'd0) |-> m_tdata[67:4] <= m_tdata[131:68])
        else $error("min above max");

endmodule

bind latency_stat_accumulator lsa_checker u_lsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the latency statistics accumulator: a directed
// set of samples and collects, then random add streams with random
// collects, checked against a per-bucket statistics predictor
// ----------------------------------------------------------------------------
module tb;
    import lsa_pkg::*;

    typedef struct {
        logic        cmd;
        logic [3:0]  bucket;
        logic [63:0] sample;
    } req_t;

    typedef struct {
        logic [3:0]  bucket;
        logic [63:0] min_v;
        logic [63:0] max_v;
        logic [63:0] mean_v;
        logic [31:0] count_v;
    } report_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [231:0] m_tdata;

    // acceptance seen at the last rising edge
    logic s_tready_q;

    latency_stat_accumulator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state, one entry per bucket
    logic [63:0] p_min   [BUCKETS];
    logic [63:0] p_max   [BUCKETS];
    logic [63:0] p_mean  [BUCKETS];
    logic [31:0] p_count [BUCKETS];
    logic [63:0] p_bsum  [BUCKETS];
    logic [31:0] p_bcnt  [BUCKETS];

    req_t    pending_reqs[$];
    report_t expected_reports[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int mismatches;
    int stall_cycles;
    bit timed_out;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] sext(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // fold the partial batch into the running mean
    function automatic void fold_batch(input int b);
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] den32;
        if (p_bcnt[b] == 0)
            return;
        num   = p_mean[b] * sext(p_count[b]) + p_bsum[b];
        den32 = p_count[b] + p_bcnt[b];
        den   = sext(den32);
        if (den32 != 0)
        begin
            if (num == 64'h8000_0000_0000_0000 && den == '1)
                p_mean[b] = num;
            else
                p_mean[b] = $signed(num) / $signed(den);
        end
        p_count[b] = den32;
        p_bsum[b]  = '0;
        p_bcnt[b]  = 0;
    endfunction

    function automatic void wipe_bucket(input int b);
        p_min[b] = '1; p_max[b] = '0; p_mean[b] = '0;
        p_count[b] = '0; p_bsum[b] = '0; p_bcnt[b] = 0;
    endfunction

    // update the statistics with one accepted transaction
    function automatic void predict_stats(input req_t r);
        int b;
        report_t rep;
        logic [63:0] s;
        b = r.bucket;
        if (r.cmd == CMD_ADD)
        begin
            if (r.sample < p_min[b]) p_min[b] = r.sample;
            if (r.sample > p_max[b]) p_max[b] = r.sample;
            s = p_bsum[b] + r.sample;
            if (s < p_bsum[b] || p_bcnt[b] + 1 >= BATCH_LIMIT)
                fold_batch(b);
            p_bsum[b] = p_bsum[b] + r.sample;
            p_bcnt[b] = p_bcnt[b] + 1;
            return;
        end
        fold_batch(b);
        rep.bucket = r.bucket;
        if (p_count[b] == 0)
        begin
            rep.min_v = '1; rep.max_v = '0; rep.mean_v = '0; rep.count_v = '0;
        end
        else
        begin
            rep.min_v = p_min[b]; rep.max_v = p_max[b];
            rep.mean_v = p_mean[b]; rep.count_v = p_count[b];
        end
        expected_reports.push_back(rep);
        wipe_bucket(b);
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return {1'b1, 63'($urandom())};
            3: return {$urandom(), $urandom()};
            default: return 64'($urandom_range(0, 100000));
        endcase
    endfunction

    task automatic queue_req(input logic cmd, input logic [3:0] b, input logic [63:0] v);
        req_t r;
        r.cmd = cmd; r.bucket = b; r.sample = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // driver: offers transactions at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_tready_q)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.cmd;
                    s_tdata  <= {4'b0, r.sample, r.bucket};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: samples both sides at the rising edge
    always @(posedge clk)
    begin
        s_tready_q <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                req_t r;
                r.cmd = s_tuser; r.bucket = s_tdata[3:0]; r.sample = s_tdata[67:4];
                predict_stats(r);
            end
            if (m_tvalid && m_tready)
            begin
                report_t e;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report transaction: %h", m_tdata);
                end
                else
                begin
                    e = expected_reports.pop_front();
                    if (m_tdata[3:0] !== e.bucket || m_tdata[67:4] !== e.min_v ||
                        m_tdata[131:68] !== e.max_v || m_tdata[195:132] !== e.mean_v ||
                        m_tdata[227:196] !== e.count_v)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp b=%0d min=%h max=%h mean=%h cnt=%h,",
                                e.bucket, e.min_v, e.max_v, e.mean_v, e.count_v,
                                " got b=%0d min=%h max=%h mean=%h cnt=%h",
                                m_tdata[3:0], m_tdata[67:4], m_tdata[131:68],
                                m_tdata[195:132], m_tdata[227:196]);
                    end
                end
            end
            // watchdog on cycles without any transaction
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int b;
        int phase_items;
        clk = 1'b0;
        rst_n = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 79;
        recv_hold = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        timed_out = 1'b0;
        s_tready_q = 1'b0;
        for (b = 0; b < BUCKETS; b++)
            wipe_bucket(b);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty collect, extremes, sum overflow, batch limit,
        // negative signed values via huge samples, buckets 0 to 3 and 15
        queue_req(CMD_COLLECT, 4'd0, '1);
        queue_req(CMD_ADD, 4'd1, '1);
        queue_req(CMD_ADD, 4'd1, '0);
        queue_req(CMD_ADD, 4'd1, '1);
        queue_req(CMD_COLLECT, 4'd1, '0);
        queue_req(CMD_ADD, 4'd15, 64'h8000_0000_0000_0000);
        queue_req(CMD_ADD, 4'd15, 64'h8000_0000_0000_0000);
        queue_req(CMD_ADD, 4'd15, 64'h7fff_ffff_ffff_ffff);
        queue_req(CMD_COLLECT, 4'd15, '0);
        queue_req(CMD_ADD, 4'd2, 64'd5);
        queue_req(CMD_COLLECT, 4'd2, '1);
        queue_req(CMD_COLLECT, 4'd2, '0);
        for (b = 0; b < 66; b++)
            queue_req(CMD_ADD, 4'd3, 64'($urandom_range(0, 1000)));
        queue_req(CMD_COLLECT, 4'd3, '0);
        wait_drained();

        // wait until the above has drained; now fill while the receiver holds
        recv_hold = 1'b1;
        for (b = 0; b < 40; b++)
            queue_req(CMD_COLLECT, 4'($urandom_range(0, 15)), rand64());
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        for (phase_items = 0; phase_items < 1030; phase_items++)
        begin
            if (phase_items == 340)
            begin
                wait_drained();
                send_idle_pct = 79; recv_idle_pct = 30;
            end
            if (phase_items == 690)
            begin
                wait_drained();
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if ($urandom_range(0, 9) == 0)
                queue_req(CMD_COLLECT, 4'($urandom_range(0, 15)), rand64());
            else
                queue_req(CMD_ADD, 4'($urandom_range(0, 3)), rand64());
            if (pending_reqs.size() > 8)
                while (pending_reqs.size() > 2)
                    @(posedge clk);
        end
        for (b = 0; b < BUCKETS; b++)
            queue_req(CMD_COLLECT, 4'(b), '0);
        wait_drained();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
